@@ rtl/tick_to_sec_nsec_reciprocal_core_macros.svh @@
// assertion macros for the tick to seconds/nanoseconds core
`ifndef TICK_TO_SEC_NSEC_RECIPROCAL_CORE_MACROS_SVH
`define TICK_TO_SEC_NSEC_RECIPROCAL_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TSN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// consequent must hold in the cycle after the antecedent
`define TSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

@@ rtl/tsn_pkg.sv @@
`default_nettype none

package tsn_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned NSEC_W = 30;
  localparam int unsigned QUOT_W = 35;
  localparam int unsigned DIG_W = 3;

  localparam logic [COUNT_W-1:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [COUNT_W-1:0] NS_TWO_SEC = 64'd2000000000;
  localparam logic [CFG_DATA_W-1:0] NS_PER_SEC_LO = NS_PER_SEC[CFG_DATA_W-1:0];

  // floor(2^61 / 10^9), quotient estimate is (hi32 * NS_RECIP) >> NS_RECIP_SH
  localparam logic [CFG_DATA_W-1:0] NS_RECIP = 32'd2305843009;
  localparam int unsigned NS_RECIP_SH = 29;

  localparam logic [CFG_DATA_W-1:0] TICK_RATE_RST = 32'd62500000;
  localparam logic [CFG_DATA_W-1:0] SEC_MUL_RST = 32'd576460752;
  localparam logic [SHIFT_W-1:0] SEC_SHIFT_RST = 6'd55;
  localparam logic [CFG_DATA_W-1:0] NS_MUL_RST = 32'h8000_0000;
  localparam logic [SHIFT_W-1:0] NS_SHIFT_RST = 6'd27;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_RATE = 3'd0,
    CFG_SEC_MUL = 3'd1,
    CFG_SEC_SHIFT = 3'd2,
    CFG_NS_MUL = 3'd3,
    CFG_NS_SHIFT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_SEC,
    OP_SUM_SEC,
    OP_MUL_RATE,
    OP_SUB_REM,
    OP_MUL_NS,
    OP_SCALE,
    OP_FIX,
    OP_DIV_MUL,
    OP_DIV_SUB,
    OP_DIV_FIX,
    OP_CARRY
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic ns_big;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/tsn_ctrl.sv @@
`default_nettype none

module tsn_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  tsn_pkg::sts_t      sts_i,
  output tsn_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_SEC,
    S_SUM_SEC,
    S_MUL_RATE,
    S_SUB_REM,
    S_MUL_NS,
    S_SCALE,
    S_FIX,
    S_DIV_MUL,
    S_DIV_SUB,
    S_DIV_FIX,
    S_CARRY
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    cmd_o.op = tsn_pkg::OP_IDLE;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tsn_pkg::OP_LOAD;
          state_d = S_MUL_SEC;
        end
      end
      S_MUL_SEC: begin
        cmd_o.op = tsn_pkg::OP_MUL_SEC;
        state_d = S_SUM_SEC;
      end
      S_SUM_SEC: begin
        cmd_o.op = tsn_pkg::OP_SUM_SEC;
        state_d = S_MUL_RATE;
      end
      S_MUL_RATE: begin
        cmd_o.op = tsn_pkg::OP_MUL_RATE;
        state_d = S_SUB_REM;
      end
      S_SUB_REM: begin
        cmd_o.op = tsn_pkg::OP_SUB_REM;
        state_d = S_MUL_NS;
      end
      S_MUL_NS: begin
        cmd_o.op = tsn_pkg::OP_MUL_NS;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = tsn_pkg::OP_SCALE;
        state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.op = tsn_pkg::OP_FIX;
        if (sts_i.ns_big) begin
          state_d = S_DIV_MUL;
        end else begin
          state_d = S_CARRY;
        end
      end
      S_DIV_MUL: begin
        cmd_o.op = tsn_pkg::OP_DIV_MUL;
        state_d = S_DIV_SUB;
      end
      S_DIV_SUB: begin
        cmd_o.op = tsn_pkg::OP_DIV_SUB;
        state_d = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        cmd_o.op = tsn_pkg::OP_DIV_FIX;
        state_d = S_CARRY;
      end
      S_CARRY: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = tsn_pkg::OP_CARRY;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/tsn_dp.sv @@
`default_nettype none

module tsn_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsn_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tsn_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic [tsn_pkg::COUNT_W-1:0]       tick_count_i,
  input  tsn_pkg::cmd_t                          cmd_i,
  output tsn_pkg::sts_t                          sts_o,
  output logic [tsn_pkg::COUNT_W-1:0]            seconds_o,
  output logic [tsn_pkg::NSEC_W-1:0]             nanoseconds_o
);

  logic [31:0] tick_rate_q, sec_mul_q, ns_mul_q;
  logic [tsn_pkg::SHIFT_W-1:0] sec_shift_q, ns_shift_q;

  logic [63:0] count_q, p0_q, p1_q, sec_q, rem_q, nsec_q;
  logic [tsn_pkg::QUOT_W-1:0] quot_q;
  logic [63:0] out_sec_q;
  logic [tsn_pkg::NSEC_W-1:0] out_nsec_q;

  logic [31:0] mul_a0, mul_a1, mul_b;
  logic [63:0] prod0, prod1, full_prod, sec_sum;
  logic [4:0] sec_sh;
  logic ns_ge_one, ns_big;
  logic [tsn_pkg::DIG_W-1:0] div_dig;
  logic [63:0] div_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= tsn_pkg::TICK_RATE_RST;
      sec_mul_q <= tsn_pkg::SEC_MUL_RST;
      sec_shift_q <= tsn_pkg::SEC_SHIFT_RST;
      ns_mul_q <= tsn_pkg::NS_MUL_RST;
      ns_shift_q <= tsn_pkg::NS_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (tsn_pkg::cfg_idx_e'(cfg_idx_i))
        tsn_pkg::CFG_TICK_RATE: tick_rate_q <= cfg_wdata_i;
        tsn_pkg::CFG_SEC_MUL:   sec_mul_q <= cfg_wdata_i;
        tsn_pkg::CFG_SEC_SHIFT: sec_shift_q <= cfg_wdata_i[tsn_pkg::SHIFT_W-1:0];
        tsn_pkg::CFG_NS_MUL:    ns_mul_q <= cfg_wdata_i;
        tsn_pkg::CFG_NS_SHIFT:  ns_shift_q <= cfg_wdata_i[tsn_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // two 32x32 multipliers, operands picked per step
  always_comb begin
    mul_a0 = count_q[63:32];
    mul_a1 = count_q[31:0];
    mul_b = sec_mul_q;
    case (cmd_i.op)
      tsn_pkg::OP_MUL_RATE: begin
        mul_a0 = sec_q[31:0];
        mul_a1 = sec_q[63:32];
        mul_b = tick_rate_q;
      end
      tsn_pkg::OP_MUL_NS: begin
        mul_a0 = rem_q[31:0];
        mul_a1 = rem_q[63:32];
        mul_b = ns_mul_q;
      end
      tsn_pkg::OP_FIX: begin
        mul_a0 = nsec_q[63:32];
        mul_b = tsn_pkg::NS_RECIP;
      end
      tsn_pkg::OP_DIV_MUL: begin
        mul_a0 = quot_q[31:0];
        mul_a1 = {{(64-tsn_pkg::QUOT_W){1'b0}}, quot_q[tsn_pkg::QUOT_W-1:32]};
        mul_b = tsn_pkg::NS_PER_SEC_LO;
      end
      default: begin
      end
    endcase
  end

  assign prod0 = {32'd0, mul_a0} * {32'd0, mul_b};
  assign prod1 = {32'd0, mul_a1} * {32'd0, mul_b};

  // low 64 bits of a 64x32 product from its two halves
  assign full_prod = p0_q + {p1_q[31:0], 32'd0};

  // shifts below 32 act as 32
  assign sec_sh = sec_shift_q[5] ? sec_shift_q[4:0] : 5'd0;
  assign sec_sum = (p0_q >> sec_sh) + ({32'd0, p1_q[63:32]} >> sec_sh);

  assign ns_ge_one = (nsec_q >= tsn_pkg::NS_PER_SEC);
  assign ns_big = (nsec_q >= tsn_pkg::NS_TWO_SEC);

  // estimate from the top 32 bits is at most seven short
  always_comb begin
    div_dig = '0;
    div_sub = '0;
    for (int k = 1; k < (1 << tsn_pkg::DIG_W); k++) begin
      if (nsec_q >= 64'(k) * tsn_pkg::NS_PER_SEC) begin
        div_dig = tsn_pkg::DIG_W'(k);
        div_sub = 64'(k) * tsn_pkg::NS_PER_SEC;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tsn_pkg::OP_LOAD: begin
        count_q <= tick_count_i;
      end
      tsn_pkg::OP_MUL_SEC, tsn_pkg::OP_MUL_RATE, tsn_pkg::OP_MUL_NS,
      tsn_pkg::OP_DIV_MUL: begin
        p0_q <= prod0;
        p1_q <= prod1;
      end
      tsn_pkg::OP_SUM_SEC: begin
        sec_q <= sec_sum;
      end
      tsn_pkg::OP_SUB_REM: begin
        rem_q <= count_q - full_prod;
      end
      tsn_pkg::OP_SCALE: begin
        nsec_q <= full_prod >> ns_shift_q;
      end
      tsn_pkg::OP_FIX: begin
        if (ns_big) begin
          quot_q <= prod0[tsn_pkg::COUNT_W-1:tsn_pkg::NS_RECIP_SH];
        end else begin
          quot_q <= {{(tsn_pkg::QUOT_W-1){1'b0}}, ns_ge_one};
          if (ns_ge_one) begin
            nsec_q <= nsec_q - tsn_pkg::NS_PER_SEC;
          end
        end
      end
      tsn_pkg::OP_DIV_SUB: begin
        nsec_q <= nsec_q - full_prod;
      end
      tsn_pkg::OP_DIV_FIX: begin
        quot_q <= quot_q + {{(tsn_pkg::QUOT_W-tsn_pkg::DIG_W){1'b0}}, div_dig};
        nsec_q <= nsec_q - div_sub;
      end
      tsn_pkg::OP_CARRY: begin
        out_sec_q <= sec_q + {{(64-tsn_pkg::QUOT_W){1'b0}}, quot_q};
        out_nsec_q <= nsec_q[tsn_pkg::NSEC_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign sts_o.ns_big = ns_big;
  assign seconds_o = out_sec_q;
  assign nanoseconds_o = out_nsec_q;

endmodule

`default_nettype wire

@@ rtl/tick_to_sec_nsec_reciprocal_core.sv @@
// Converts a 64-bit tick count into whole seconds and nanoseconds using the
// reciprocal constants held in five registers (tick_rate, sec_mul, sec_shift,
// ns_mul, ns_shift; write them only while the core is idle). A conversion runs
// through a fixed sequence of two-multiplier steps (seconds estimate, remainder,
// nanosecond scaling) and a carry step. Input is stalled until the carry step
// has run, and the result is offered in the cycle the next input can be taken.
// When the scaled nanoseconds reach two billion or more, which only inconsistent
// register settings produce, a reciprocal-multiply divide by one billion with
// multiply, subtract and final correction steps precedes the carry step. The
// result sits in an output register, so a new input is taken while it waits to
// be transferred; the next conversion's carry step waits for that transfer.
`default_nettype none

module tick_to_sec_nsec_reciprocal_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsn_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tsn_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tsn_pkg::COUNT_W-1:0]       tick_count_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tsn_pkg::COUNT_W-1:0]            seconds_o,
  output logic [tsn_pkg::NSEC_W-1:0]             nanoseconds_o
);

  tsn_pkg::cmd_t cmd;
  tsn_pkg::sts_t sts;

  tsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .tick_count_i  (tick_count_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .seconds_o     (seconds_o),
    .nanoseconds_o (nanoseconds_o)
  );

endmodule

`default_nettype wire

@@ rtl/tsn_checker.sv @@
`default_nettype none
`include "tick_to_sec_nsec_reciprocal_core_macros.svh"

module tsn_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [tsn_pkg::NSEC_W-1:0]    nanoseconds_o
);

  // a transfer in keeps the core busy on the next cycle
  `TSN_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // fraction below one second whenever a result is offered
  `TSN_ASSERT(a_ns_range, clk_i, rst_ni, out_valid_o |-> (nanoseconds_o < 30'(tsn_pkg::NS_PER_SEC)))

  // a result only appears at the end of a conversion
  `TSN_ASSERT(a_out_after_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

  `TSN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind tick_to_sec_nsec_reciprocal_core tsn_checker u_tsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .nanoseconds_o (nanoseconds_o)
);

`default_nettype wire

@@ tb/sv/timespec_checker.sv @@
`timescale 1ns / 1ps

module timespec_checker
  import tsn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [COUNT_W-1:0]    tick_count_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [COUNT_W-1:0]    seconds_i,
  input  logic [NSEC_W-1:0]     nanoseconds_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned HALF_SHIFT = 32;

  typedef struct packed {
    logic [COUNT_W-1:0] seconds;
    logic [NSEC_W-1:0]  nanoseconds;
  } timespec_t;

  timespec_t timespec_q[$];
  timespec_t want;

  logic [CFG_DATA_W-1:0] rate_r;
  logic [CFG_DATA_W-1:0] sec_mul_r;
  logic [SHIFT_W-1:0]    sec_shift_r;
  logic [CFG_DATA_W-1:0] ns_mul_r;
  logic [SHIFT_W-1:0]    ns_shift_r;

  function automatic timespec_t convert_ticks(input logic [COUNT_W-1:0] count);
    logic [SHIFT_W-1:0] s;
    logic [COUNT_W-1:0] hi_prod;
    logic [COUNT_W-1:0] lo_prod;
    logic [COUNT_W-1:0] sec;
    logic [COUNT_W-1:0] rem;
    logic [COUNT_W-1:0] prod;
    logic [COUNT_W-1:0] ns;
    timespec_t ts;
    // seconds shift below 32 acts as 32
    s = (sec_shift_r < SHIFT_W'(HALF_SHIFT)) ? SHIFT_W'(HALF_SHIFT) : sec_shift_r;
    hi_prod = {32'd0, count[63:32]} * {32'd0, sec_mul_r};
    lo_prod = {32'd0, count[31:0]} * {32'd0, sec_mul_r};
    sec = (hi_prod >> (s - HALF_SHIFT)) + (lo_prod >> s);
    rem = count - sec * {32'd0, rate_r};
    prod = rem * {32'd0, ns_mul_r};
    ns = prod >> ns_shift_r;
    sec = sec + ns / NS_PER_SEC;
    ns = ns % NS_PER_SEC;
    ts.seconds = sec;
    ts.nanoseconds = ns[NSEC_W-1:0];
    return ts;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_r <= TICK_RATE_RST;
      sec_mul_r <= SEC_MUL_RST;
      sec_shift_r <= SEC_SHIFT_RST;
      ns_mul_r <= NS_MUL_RST;
      ns_shift_r <= NS_SHIFT_RST;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TICK_RATE: rate_r <= cfg_wdata_i;
          CFG_SEC_MUL: sec_mul_r <= cfg_wdata_i;
          CFG_SEC_SHIFT: sec_shift_r <= cfg_wdata_i[SHIFT_W-1:0];
          CFG_NS_MUL: ns_mul_r <= cfg_wdata_i;
          CFG_NS_SHIFT: ns_shift_r <= cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (timespec_q.size() == 0) begin
          $error("result transfer with no conversion pending: seconds %0d nanoseconds %0d",
                 seconds_i, nanoseconds_i);
          fail_count_o++;
        end else begin
          want = timespec_q.pop_front();
          if (seconds_i !== want.seconds) begin
            $error("seconds: expected %0d, got %0d", want.seconds, seconds_i);
            fail_count_o++;
          end
          if (nanoseconds_i !== want.nanoseconds) begin
            $error("nanoseconds: expected %0d, got %0d", want.nanoseconds, nanoseconds_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        timespec_q.push_back(convert_ticks(tick_count_i));
      end
      pending_o = timespec_q.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tsn_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 800000;
  localparam int unsigned RAND_SETTINGS = 14;
  localparam int unsigned ITEMS_PER_SETTING = 125;
  localparam int unsigned END_WAIT = 50;
  localparam logic [63:0] BILLION = 64'd1000000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COUNT_W-1:0]    tick_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_W-1:0]    seconds;
  logic [NSEC_W-1:0]     nanoseconds;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned           in_idle_pct = 33;
  int unsigned           out_stall_pct = 72;
  int unsigned           cycles = 0;
  logic [31:0]           cur_rate = TICK_RATE_RST;

  tick_to_sec_nsec_reciprocal_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .tick_count_i (tick_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .seconds_o    (seconds),
    .nanoseconds_o(nanoseconds)
  );

  timespec_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .tick_count_i (tick_count),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .seconds_i    (seconds),
    .nanoseconds_i(nanoseconds),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** tick_to_sec_nsec_reciprocal_core: FAILED **");
      $finish;
    end
  end

  task automatic send_tick(input logic [COUNT_W-1:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    tick_count = c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off input until every conversion has been transferred out
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_unused_regs();
    for (int i = int'(CFG_NS_SHIFT) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), $urandom());
    end
  endtask

  task automatic apply_settings(input logic [31:0] f, input logic [31:0] sm,
                                input logic [5:0] s, input logic [31:0] nm,
                                input logic [5:0] n);
    settle();
    cur_rate = f;
    write_reg(CFG_TICK_RATE, f);
    write_reg(CFG_SEC_MUL, sm);
    write_reg(CFG_SEC_SHIFT, {26'($urandom()), s});
    write_reg(CFG_NS_MUL, nm);
    write_reg(CFG_NS_SHIFT, {26'($urandom()), n});
    if ($urandom_range(3) == 0) write_unused_regs();
  endtask

  // largest shift whose reciprocal still fits 32 bits
  function automatic int fit_shift(input logic [31:0] f, input logic [63:0] scale, input int hi);
    int sh;
    for (sh = hi; sh > 0; sh--) begin
      if (((128'(scale) << sh) / 128'(f)) < (128'd1 << 32)) return sh;
    end
    return 0;
  endfunction

  function automatic logic [31:0] recip(input logic [31:0] f, input logic [63:0] scale,
                                        input int sh);
    return 32'((128'(scale) << sh) / 128'(f));
  endfunction

  task automatic apply_matched(input logic [31:0] f, input bit lower);
    int s;
    int n;
    s = fit_shift(f, 64'd1, 55);
    n = fit_shift(f, BILLION, 55);
    if (lower) begin
      s = $urandom_range(s, 32);
      n = $urandom_range(n, 0);
    end
    apply_settings(f, recip(f, 64'd1, s), 6'(s), recip(f, BILLION, n), 6'(n));
  endtask

  function automatic logic [5:0] pick_edge_shift();
    case ($urandom_range(4))
      0: return 6'd0;
      1: return 6'd31;
      2: return 6'd32;
      3: return 6'd55;
      default: return 6'd63;
    endcase
  endfunction

  task automatic choose_settings(input int k);
    case (k % 7)
      0: apply_matched($urandom_range(100000000, 1000000), 1'b0);
      1: apply_matched($urandom_range(1000, 2), 1'b0);
      2: apply_matched(($urandom_range(3) == 0) ? 32'hFFFF_FFFF : ($urandom() | 32'h8000_0000),
                       1'b0);
      3: apply_matched($urandom_range(32'hFFFF_FFFF, 2), 1'b1);
      4: apply_settings($urandom_range(1), $urandom(), 6'($urandom_range(63)), $urandom(),
                        6'($urandom_range(63)));
      5: apply_settings($urandom(), $urandom(), 6'($urandom_range(63)), $urandom(),
                        6'($urandom_range(63)));
      default: apply_settings(($urandom_range(1) != 0) ? 32'd2 : 32'hFFFF_FFFF,
                              ($urandom_range(1) != 0) ? 32'd0 : 32'hFFFF_FFFF,
                              pick_edge_shift(),
                              ($urandom_range(1) != 0) ? 32'd0 : 32'hFFFF_FFFF,
                              pick_edge_shift());
    endcase
  endtask

  function automatic logic [COUNT_W-1:0] pick_tick();
    logic [COUNT_W-1:0] k;
    k = {$urandom(), $urandom()} >> $urandom_range(63, 8);
    case ($urandom_range(7))
      0: return {$urandom(), $urandom()};
      1: return {$urandom(), $urandom()} >> $urandom_range(63);
      2: return k * {32'd0, cur_rate} + 64'($urandom_range(3));
      3: return k * {32'd0, cur_rate} - 64'(1 + $urandom_range(2));
      4: return '1 - 64'($urandom_range(3));
      5: return {32'd0, $urandom()};
      6: return 64'($urandom_range(3));
      default: return {32'($urandom_range(1)), 32'hFFFF_FFFF} + 64'($urandom_range(2));
    endcase
  endfunction

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings
    send_tick(64'd0);
    send_tick(64'd1);
    send_tick(64'd62499999);
    send_tick(64'd62500000);
    send_tick(64'hFFFF_FFFF);
    send_tick(64'h1_0000_0000);
    send_tick(64'd62500000 * 64'd1000 + 64'd62499999);
    send_tick('1);

    // lowest rate
    apply_matched(32'd2, 1'b0);
    send_tick(64'd0);
    send_tick(64'd1);
    send_tick(64'd2);
    send_tick(64'd3);
    send_tick('1);

    // highest rate
    apply_matched(32'hFFFF_FFFF, 1'b0);
    send_tick(64'hFFFF_FFFE);
    send_tick(64'hFFFF_FFFF);
    send_tick('1);

    // seconds shift below 32, nanoseconds shift past 55
    apply_settings(32'd62500000, 32'd68, 6'd5, $urandom(), 6'd60);
    send_tick({$urandom(), $urandom()});
    send_tick('1);

    // billions carry with a huge excess
    apply_settings(32'd1000, 32'd0, 6'd40, 32'hFFFF_FFFF, 6'd0);
    send_tick('1);
    send_tick({$urandom(), $urandom()});

    // zero and unit rates
    apply_settings(32'd0, $urandom(), 6'd33, $urandom(), 6'd20);
    send_tick({$urandom(), $urandom()});
    apply_settings(32'd1, $urandom(), 6'd32, $urandom(), 6'd0);
    send_tick({$urandom(), $urandom()});

    // writes to unused indexes change nothing
    settle();
    write_unused_regs();
    send_tick({$urandom(), $urandom()});

    for (int k = 0; k < RAND_SETTINGS; k++) begin
      if (k < 5) begin
        in_idle_pct = 33;
        out_stall_pct = 72;
      end else if (k < 10) begin
        in_idle_pct = 72;
        out_stall_pct = 33;
      end else begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      choose_settings(k);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if ($urandom_range(99) == 0) settle();
        send_tick(pick_tick());
      end
    end

    settle();
    repeat (END_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** tick_to_sec_nsec_reciprocal_core: PASSED **");
    end else begin
      $display("** tick_to_sec_nsec_reciprocal_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ tick_to_sec_nsec_reciprocal_core.f @@
+incdir+rtl
rtl/tsn_pkg.sv
rtl/tsn_ctrl.sv
rtl/tsn_dp.sv
rtl/tick_to_sec_nsec_reciprocal_core.sv
rtl/tsn_checker.sv
tb/sv/timespec_checker.sv
tb/sv/tb.sv
